FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands for the FSK demodulator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// An expression that must hold at every clock edge outside reset.
`define ASSERT_HOLD(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("invariant violated");
// A property, normally an implication, checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("implication violated");
`else
`define ASSERT_HOLD(label, clk, rst_n, expr)
`define ASSERT_IMPL(label, clk, rst_n, prop)
`endif
`endif

FILE: rtl/fsk_pkg.sv
// ----------------------------------------------------------------------------
// FSK demodulator package
// Shared constants, types, the quarter-wave sine table and arithmetic helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package fsk_pkg;

	localparam int SAMPLE_W        = 16;
	localparam int HILBERT_TAPS    = 101;
	localparam int CENTER          = (HILBERT_TAPS - 1) / 2;
	localparam int COEF_HALF       = 25;
	localparam int WINDOW_MAX      = 64;
	localparam int SINE_TABLE_BITS = 10;
	localparam int QUARTER         = 2 ** (SINE_TABLE_BITS - 2);
	localparam int DECIM_MID       = 25;
	localparam int DECIM_END       = 50;
	localparam int DECIM_W         = 6;
	localparam int QUEUE_DEPTH     = 4;
	localparam int PADDR_W         = 4;

	localparam int TAP_AW  = $clog2(HILBERT_TAPS);
	localparam int TAP_CW  = $clog2(HILBERT_TAPS + 1);
	localparam int COEF_AW = $clog2(COEF_HALF);
	localparam int WIN_AW  = $clog2(WINDOW_MAX);
	localparam int WIN_CW  = $clog2(WINDOW_MAX + 1);
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);
	localparam int FIR_ISSUES = 2 * COEF_HALF + 1;
	localparam int FIR_LAST   = FIR_ISSUES + 1;
	localparam int STEP_MAX   = (FIR_LAST > WINDOW_MAX) ? FIR_LAST : WINDOW_MAX;
	localparam int STEP_W     = $clog2(STEP_MAX + 1);
	localparam int ACC_W      = 40;
	localparam int MIX_W      = 18;

	localparam logic [31:0] TONE0_STEP_RST = 32'd515396076;
	localparam logic [31:0] TONE1_STEP_RST = 32'd558345748;
	localparam logic [6:0]  WINDOW_LEN_RST = 7'd50;

	localparam logic [1:0] REG_TONE0_STEP = 2'd0;
	localparam logic [1:0] REG_TONE1_STEP = 2'd1;
	localparam logic [1:0] REG_WINDOW_LEN = 2'd2;

	localparam logic [15:0] HALF_COEF [COEF_HALF] = '{
		16'd20832, 16'd6866, 16'd4028, 16'd2782, 16'd2067, 16'd1598, 16'd1262,
		16'd1008, 16'd810, 16'd651, 16'd522, 16'd416, 16'd330, 16'd258,
		16'd200, 16'd153, 16'd115, 16'd85, 16'd61, 16'd43, 16'd29, 16'd19,
		16'd12, 16'd7, 16'd4
	};

	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
	localparam logic [63:0] TAYLOR_DIV [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

	typedef logic [15:0] qtab_t [QUARTER];

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] audio_sample;
		logic                       emit;
		logic                       decim_phase;
	} q_item_t;

	typedef struct packed {
		logic    valid;
		q_item_t item;
	} q_head_t;

	typedef struct packed {
		logic [31:0] tone0_phase_step;
		logic [31:0] tone1_phase_step;
		logic [6:0]  window_len;
	} cfg_t;

	typedef struct packed {
		logic signed [MIX_W-1:0] t1_re;
		logic signed [MIX_W-1:0] t1_im;
		logic signed [MIX_W-1:0] t0_re;
		logic signed [MIX_W-1:0] t0_im;
	} win_entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIR,
		ST_FIN,
		ST_MIX,
		ST_WRITE,
		ST_SUM,
		ST_SQR_RE,
		ST_SQR_IM,
		ST_OUT
	} state_t;

	// Sine on the first quarter wave: Taylor series in Q30, scaled to 32767.
	function automatic logic [15:0] quarter_sine(input int unsigned q);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		int i;
		x = (64'(q) * Q30_HALF_PI) / QUARTER;
		x2 = (x * x) >> 30;
		t = Q30_ONE;
		for (i = 0; i < 5; i++) begin
			t = Q30_ONE - ((x2 * t) >> 30) / TAYLOR_DIV[i];
		end
		s = (x * t) >> 30;
		s = (s * 64'd32767 + 64'd536870912) >> 30;
		return (s > 64'd32767) ? 16'd32767 : s[15:0];
	endfunction

	// Entry m holds the quarter-wave sine at step m + 1; step 0 is zero.
	function automatic qtab_t build_qtab();
		qtab_t tab;
		int m;
		for (m = 0; m < QUARTER; m++) begin
			tab[m] = quarter_sine(m + 1);
		end
		return tab;
	endfunction

	localparam qtab_t QTAB = build_qtab();

	function automatic logic signed [15:0] sine_at(input logic [SINE_TABLE_BITS-1:0] k);
		logic [1:0]                 quad;
		logic [SINE_TABLE_BITS-3:0] r;
		logic [SINE_TABLE_BITS-2:0] m;
		logic [SINE_TABLE_BITS-2:0] mi;
		logic signed [15:0]         v;
		quad = k[SINE_TABLE_BITS-1 -: 2];
		r = k[SINE_TABLE_BITS-3:0];
		m = quad[0] ? ((SINE_TABLE_BITS-1)'(QUARTER) - {1'b0, r}) : {1'b0, r};
		mi = m - 1'b1;
		v = (m == '0) ? 16'sd0 : $signed(QTAB[mi[SINE_TABLE_BITS-3:0]]);
		return quad[1] ? -v : v;
	endfunction

	// Round off 15 fraction bits and saturate to a 16-bit sample.
	function automatic logic signed [15:0] round_sat16(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		r = (v + ACC_W'(16384)) >>> 15;
		if ((&r[ACC_W-1:15]) || !(|r[ACC_W-1:15])) begin
			return r[15:0];
		end
		return r[ACC_W-1] ? 16'sh8000 : 16'sh7fff;
	endfunction

	// Round a mixer sum from Q3.30 to Q3.15; the result always fits MIX_W bits.
	function automatic logic signed [MIX_W-1:0] round_mix(input logic signed [32:0] v);
		logic signed [32:0] r;
		r = (v + 33'sd16384) >>> 15;
		return r[MIX_W-1:0];
	endfunction

	function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
			input logic signed [MIX_W-1:0] b);
		logic signed [32:0] s;
		s = {a[31], a} + {{(33 - MIX_W){b[MIX_W-1]}}, b};
		if (s[32] != s[31]) begin
			return s[32] ? 32'sh80000000 : 32'sh7fffffff;
		end
		return s[31:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/fsk_sample_if.sv
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one audio sample per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface fsk_sample_if;
	import fsk_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] audio_sample;

	modport source (output valid, output audio_sample, input ready);
	modport sink (input valid, input audio_sample, output ready);
endinterface

`default_nettype wire

FILE: rtl/fsk_chip_if.sv
// ----------------------------------------------------------------------------
// Chip channel
// Valid/ready channel carrying one demodulated chip per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface fsk_chip_if;
	logic valid;
	logic ready;
	logic chip_value;
	logic decim_phase;

	modport source (output valid, output chip_value, output decim_phase, input ready);
	modport sink (input valid, input chip_value, input decim_phase, output ready);
endinterface

`default_nettype wire

FILE: rtl/two_tone_fsk_demodulator.sv
// ----------------------------------------------------------------------------
// Two-tone FSK demodulator
// Hilbert analytic signal, two tone mixers with window sums, chip decisions.
// ----------------------------------------------------------------------------
//
//  Channel    Kind           Payload                       Per request
//  sample_ch  valid/ready in audio_sample (s16, Q1.15)     one audio sample
//  chip_ch    valid/ready out chip_value, decim_phase      one chip
//  APB        psel/penable   steps of both tones, window   one register write
//
//  Each sample passes through the back end in turn: first the Hilbert filter, with
//  one tap read per cycle from the single-port tap memory, then the tone mixers,
//  then a walk through the window memory over the L newest rows, L being the
//  effective window length (50 by default, at most 64).
//  The front end keeps taking samples into a four-entry queue while the back end
//  works, and a finished chip waits in an output register; the back end stalls
//  only when a chip is due and the previous one has not been taken.
//  Reset is asynchronous and needs no clearing pass: fill counts on the tap and
//  window memories make unwritten entries read as zero.
//
`default_nettype none

module two_tone_fsk_demodulator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fsk_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	fsk_sample_if.sink                  sample_ch,
	fsk_chip_if.source                  chip_ch
);
	import fsk_pkg::*;

	cfg_t    cfg_q;
	q_head_t head;
	logic    pop;
	logic    cfg_wr;

	// The port never stalls; a write lands at the access phase of the request.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tone0_phase_step <= TONE0_STEP_RST;
			cfg_q.tone1_phase_step <= TONE1_STEP_RST;
			cfg_q.window_len <= WINDOW_LEN_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_TONE0_STEP: cfg_q.tone0_phase_step <= pwdata;
				REG_TONE1_STEP: cfg_q.tone1_phase_step <= pwdata;
				REG_WINDOW_LEN: cfg_q.window_len <= pwdata[6:0];
				default: begin
				end
			endcase
		end
	end

	// Read-back; addresses beyond the register list read as zero.
	always_comb begin
		unique case (paddr[3:2])
			REG_TONE0_STEP: prdata = cfg_q.tone0_phase_step;
			REG_TONE1_STEP: prdata = cfg_q.tone1_phase_step;
			REG_WINDOW_LEN: prdata = {25'd0, cfg_q.window_len};
			default:        prdata = '0;
		endcase
	end

	// The front end counts the decimation period, so each queued sample already
	// knows whether it yields a chip and with which phase tag.
	fsk_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.pop       (pop),
		.head      (head)
	);

	// The back end runs the filter, mixers, window sums and the decision.
	fsk_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.head    (head),
		.pop     (pop),
		.chip_ch (chip_ch)
	);

endmodule

`default_nettype wire

FILE: rtl/fsk_front.sv
// ----------------------------------------------------------------------------
// FSK front end
// Accepts samples, tags them with the decimation outcome and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module fsk_front (
	input  logic            clk,
	input  logic            arst_n,
	fsk_sample_if.sink      sample_ch,
	input  logic            pop,
	output fsk_pkg::q_head_t head
);
	import fsk_pkg::*;

	logic [DECIM_W-1:0]  decim_q;
	logic [DECIM_W-1:0]  decim_inc;
	logic                push;
	q_item_t             item_in;
	q_item_t             q_mem [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;

	assign sample_ch.ready = (count_q != QUEUE_CW'(QUEUE_DEPTH));
	assign push = sample_ch.valid && sample_ch.ready;
	assign decim_inc = decim_q + 1'b1;

	// A chip falls due at the middle and at the end of every decimation period.
	always_comb begin
		item_in.audio_sample = sample_ch.audio_sample;
		item_in.emit = (decim_inc == DECIM_W'(DECIM_MID)) || (decim_inc >= DECIM_W'(DECIM_END));
		item_in.decim_phase = (decim_inc >= DECIM_W'(DECIM_END));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decim_q <= '0;
		end else if (push) begin
			decim_q <= (decim_inc >= DECIM_W'(DECIM_END)) ? '0 : decim_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			priority if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head.valid = (count_q != '0);
	assign head.item = q_mem[rd_ptr_q];

endmodule

`default_nettype wire

FILE: rtl/fsk_back.sv
// ----------------------------------------------------------------------------
// FSK back end
// Hilbert filter, tone mixers, window sums and tone decision for one sample.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fsk_back (
	input  logic             clk,
	input  logic             arst_n,
	input  fsk_pkg::cfg_t    cfg,
	input  fsk_pkg::q_head_t head,
	output logic             pop,
	fsk_chip_if.source       chip_ch
);
	import fsk_pkg::*;

	state_t state_q;
	state_t state_d;
	logic [STEP_W-1:0] step_q;
	logic tap_issue;
	logic win_issue;
	logic out_load;

	logic emit_q;
	logic phase_q;

	// Hilbert tap store, circular, newest sample at tap_wp_q.
	logic signed [SAMPLE_W-1:0] tap_mem [HILBERT_TAPS];
	logic [TAP_AW-1:0] tap_wp_q;
	logic [TAP_AW-1:0] tap_wp_next;
	logic [TAP_CW-1:0] tap_cnt_q;
	logic [TAP_AW-1:0] tap_idx;
	logic [TAP_AW:0]   tap_diff;
	logic [TAP_AW-1:0] tap_addr;
	logic [TAP_AW-1:0] tap_off;
	logic [COEF_AW-1:0] coef_k;
	logic fir_center;
	logic tap_ok;

	logic signed [SAMPLE_W-1:0] tap_rd_s1;
	logic signed [16:0]         coef_s1;
	logic                       live_s1;
	logic                       cen_s1;
	logic                       cen_ok_s1;
	logic signed [32:0]         prod_s2;
	logic                       prod_v_s2;
	logic signed [ACC_W-1:0]    acc_q;

	logic signed [15:0] re_q;
	logic signed [15:0] im_q;
	logic [31:0] ph0_q;
	logic [31:0] ph1_q;
	logic [SINE_TABLE_BITS-1:0] sidx0;
	logic [SINE_TABLE_BITS-1:0] sidx1;
	logic signed [15:0] s0_q;
	logic signed [15:0] c0_q;
	logic signed [15:0] s1_q;
	logic signed [15:0] c1_q;

	logic signed [15:0] mix_a;
	logic signed [15:0] mix_b0;
	logic signed [15:0] mix_b1;
	logic signed [31:0] mprod0_s1;
	logic signed [31:0] mprod1_s1;
	logic signed [32:0] mr0_q;
	logic signed [32:0] mi0_q;
	logic signed [32:0] mr1_q;
	logic signed [32:0] mi1_q;

	// Window store, both tones in one row, newest row at win_wp_q.
	win_entry_t win_mem [WINDOW_MAX];
	logic [WIN_AW-1:0] win_wp_q;
	logic [WIN_CW-1:0] win_cnt_q;
	logic [WIN_CW-1:0] wlen;
	logic [WIN_AW-1:0] win_addr;
	logic win_ok;
	win_entry_t win_new;
	win_entry_t win_rd_s1;
	logic wlive_s1;
	logic signed [31:0] sr0_q;
	logic signed [31:0] si0_q;
	logic signed [31:0] sr1_q;
	logic signed [31:0] si1_q;

	logic signed [63:0] sqa0;
	logic signed [63:0] sqa1;
	logic [63:0] mag0_q;
	logic [63:0] mag1_q;

	logic out_v_q;
	logic out_chip_q;
	logic out_phase_q;

	// Effective window length: zero acts as one, anything longer than the store is clipped.
	always_comb begin
		if (cfg.window_len == '0) begin
			wlen = WIN_CW'(1);
		end else if (32'(cfg.window_len) > WINDOW_MAX) begin
			wlen = WIN_CW'(WINDOW_MAX);
		end else begin
			wlen = WIN_CW'(cfg.window_len);
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					state_d = ST_FIR;
				end
			end
			ST_FIR: begin
				if (step_q == STEP_W'(FIR_LAST)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN:   state_d = ST_MIX;
			ST_MIX: begin
				if (step_q == STEP_W'(4)) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: state_d = ST_SUM;
			ST_SUM: begin
				if (32'(step_q) == 32'(wlen)) begin
					state_d = ST_SQR_RE;
				end
			end
			ST_SQR_RE: state_d = ST_SQR_IM;
			ST_SQR_IM: state_d = ST_OUT;
			ST_OUT: begin
				if (!emit_q || !out_v_q) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		pop = 1'b0;
		tap_issue = 1'b0;
		win_issue = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: pop = head.valid;
			ST_FIR:  tap_issue = (32'(step_q) < FIR_ISSUES);
			ST_SUM:  win_issue = (32'(step_q) < 32'(wlen));
			ST_OUT:  out_load = emit_q && !out_v_q;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			step_q <= (state_d != state_q) ? '0 : step_q + 1'b1;
		end
	end

	// Tap addressing: even steps take the newer-side partner of an odd offset,
	// which carries the negated coefficient; the last step fetches the centre tap.
	assign fir_center = (32'(step_q) == FIR_ISSUES - 1);
	assign coef_k = fir_center ? '0 : step_q[COEF_AW:1];
	assign tap_off = TAP_AW'({coef_k, 1'b1});
	always_comb begin
		if (fir_center) begin
			tap_idx = TAP_AW'(CENTER);
		end else if (step_q[0]) begin
			tap_idx = TAP_AW'(CENTER) + tap_off;
		end else begin
			tap_idx = TAP_AW'(CENTER) - tap_off;
		end
	end
	assign tap_diff = {1'b0, tap_wp_q} - {1'b0, tap_idx};
	assign tap_addr = tap_diff[TAP_AW] ? (tap_diff[TAP_AW-1:0] + TAP_AW'(HILBERT_TAPS))
		: tap_diff[TAP_AW-1:0];
	assign tap_ok = (32'(tap_idx) < 32'(tap_cnt_q));
	assign tap_wp_next = (tap_wp_q == TAP_AW'(HILBERT_TAPS - 1)) ? '0 : tap_wp_q + 1'b1;

	always_ff @(posedge clk) begin
		if (pop) begin
			tap_mem[tap_wp_next] <= head.item.audio_sample;
		end
		if (tap_issue) begin
			tap_rd_s1 <= tap_mem[tap_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_wp_q <= '0;
			tap_cnt_q <= '0;
			live_s1 <= 1'b0;
			cen_s1 <= 1'b0;
			prod_v_s2 <= 1'b0;
			emit_q <= 1'b0;
			phase_q <= 1'b0;
			ph0_q <= '0;
			ph1_q <= '0;
			win_wp_q <= '0;
			win_cnt_q <= '0;
			wlive_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (pop) begin
				tap_wp_q <= tap_wp_next;
				emit_q <= head.item.emit;
				phase_q <= head.item.decim_phase;
				if (tap_cnt_q != TAP_CW'(HILBERT_TAPS)) begin
					tap_cnt_q <= tap_cnt_q + 1'b1;
				end
			end
			live_s1 <= tap_issue && tap_ok && !fir_center;
			cen_s1 <= tap_issue && fir_center;
			prod_v_s2 <= live_s1;
			if (state_q == ST_FIN) begin
				ph0_q <= ph0_q + cfg.tone0_phase_step;
				ph1_q <= ph1_q + cfg.tone1_phase_step;
			end
			if (state_q == ST_WRITE) begin
				win_wp_q <= win_wp_q + 1'b1;
				if (win_cnt_q != WIN_CW'(WINDOW_MAX)) begin
					win_cnt_q <= win_cnt_q + 1'b1;
				end
			end
			wlive_s1 <= win_issue && win_ok;
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (chip_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Hilbert multiply-accumulate pipeline
	always_ff @(posedge clk) begin
		if (tap_issue) begin
			coef_s1 <= step_q[0] ? $signed({1'b0, HALF_COEF[coef_k]})
				: -$signed({1'b0, HALF_COEF[coef_k]});
			cen_ok_s1 <= tap_ok;
		end
		if (live_s1) begin
			prod_s2 <= tap_rd_s1 * coef_s1;
		end
		if (cen_s1) begin
			re_q <= cen_ok_s1 ? tap_rd_s1 : 16'sd0;
		end
		if (pop) begin
			acc_q <= '0;
		end else if (prod_v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// Oscillators: table index from the phase before it advances.
	assign sidx0 = ph0_q[31 -: SINE_TABLE_BITS];
	assign sidx1 = ph1_q[31 -: SINE_TABLE_BITS];

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN) begin
			im_q <= round_sat16(acc_q);
			s0_q <= sine_at(sidx0);
			c0_q <= sine_at(sidx0 + SINE_TABLE_BITS'(QUARTER));
			s1_q <= sine_at(sidx1);
			c1_q <= sine_at(sidx1 + SINE_TABLE_BITS'(QUARTER));
		end
	end

	// Mixer: products re*cos, im*sin, im*cos, re*sin in turn, registered and combined in the next step.
	assign mix_a = (step_q == STEP_W'(0) || step_q == STEP_W'(3)) ? re_q : im_q;
	assign mix_b0 = step_q[0] ? s0_q : c0_q;
	assign mix_b1 = step_q[0] ? s1_q : c1_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_MIX) begin
			mprod0_s1 <= mix_a * mix_b0;
			mprod1_s1 <= mix_a * mix_b1;
			unique case (step_q)
				STEP_W'(1): begin
					mr0_q <= 33'(mprod0_s1);
					mr1_q <= 33'(mprod1_s1);
				end
				STEP_W'(2): begin
					mr0_q <= mr0_q + 33'(mprod0_s1);
					mr1_q <= mr1_q + 33'(mprod1_s1);
				end
				STEP_W'(3): begin
					mi0_q <= 33'(mprod0_s1);
					mi1_q <= 33'(mprod1_s1);
				end
				STEP_W'(4): begin
					mi0_q <= mi0_q - 33'(mprod0_s1);
					mi1_q <= mi1_q - 33'(mprod1_s1);
				end
				default: begin
				end
			endcase
		end
	end

	// Window store and per-tone saturating window sums
	always_comb begin
		win_new.t1_re = round_mix(mr1_q);
		win_new.t1_im = round_mix(mi1_q);
		win_new.t0_re = round_mix(mr0_q);
		win_new.t0_im = round_mix(mi0_q);
	end
	assign win_addr = win_wp_q - step_q[WIN_AW-1:0];
	assign win_ok = (32'(step_q) < 32'(win_cnt_q));

	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE) begin
			win_mem[win_wp_q + 1'b1] <= win_new;
		end
		if (win_issue) begin
			win_rd_s1 <= win_mem[win_addr];
		end
		if (state_q == ST_WRITE) begin
			sr0_q <= '0;
			si0_q <= '0;
			sr1_q <= '0;
			si1_q <= '0;
		end else if (wlive_s1) begin
			sr0_q <= sat_add32(sr0_q, win_rd_s1.t0_re);
			si0_q <= sat_add32(si0_q, win_rd_s1.t0_im);
			sr1_q <= sat_add32(sr1_q, win_rd_s1.t1_re);
			si1_q <= sat_add32(si1_q, win_rd_s1.t1_im);
		end
	end

	// Squared magnitudes, real part first, then the imaginary part added on.
	always_comb begin
		if (state_q == ST_SQR_RE) begin
			sqa0 = sr0_q * sr0_q;
			sqa1 = sr1_q * sr1_q;
		end else begin
			sqa0 = si0_q * si0_q;
			sqa1 = si1_q * si1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SQR_RE) begin
			mag0_q <= 64'(sqa0);
			mag1_q <= 64'(sqa1);
		end else if (state_q == ST_SQR_IM) begin
			mag0_q <= mag0_q + 64'(sqa0);
			mag1_q <= mag1_q + 64'(sqa1);
		end
		if (out_load) begin
			out_chip_q <= (mag1_q > mag0_q);
			out_phase_q <= phase_q;
		end
	end

	assign chip_ch.valid = out_v_q;
	assign chip_ch.chip_value = out_chip_q;
	assign chip_ch.decim_phase = out_phase_q;

	`ASSERT_IMPL(a_idle_holds, clk, arst_n, (state_q == ST_IDLE && !head.valid) |=> (state_q == ST_IDLE))
	`ASSERT_IMPL(a_fir_bound, clk, arst_n, (state_q == ST_FIR) |-> (32'(step_q) <= FIR_LAST))
	`ASSERT_IMPL(a_sum_bound, clk, arst_n, (state_q == ST_SUM) |-> (32'(step_q) <= 32'(wlen)))
	`ASSERT_HOLD(a_tap_fill, clk, arst_n, 32'(tap_cnt_q) <= HILBERT_TAPS)

endmodule

`default_nettype wire
